// ----- rtl/blcc_pkg.sv -----
// Shared types, constants and color tables for the button lamp color controller.
// No dependencies; every other file uses this package.
package blcc_pkg;

  localparam int LevelW     = 8;
  localparam int ColorSlotW = 3;
  localparam int IntSlotW   = 4;
  localparam int CfgIdxW    = 2;
  localparam int NumColors  = 7;
  localparam int NumLevels  = 9;

  localparam logic [ColorSlotW-1:0] RAINBOW_SLOT = ColorSlotW'(7);
  localparam logic [IntSlotW-1:0]   LAST_LEVEL   = IntSlotW'(NumLevels - 1);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_PRESS   = 2'd0,
    CFG_IDLE_TIMEOUT = 2'd1
  } cfg_idx_t;

  // Rainbow fade phases
  typedef enum logic [5:0] {
    PH_BLUE_UP    = 6'b000001,
    PH_RED_DOWN   = 6'b000010,
    PH_GREEN_UP   = 6'b000100,
    PH_BLUE_DOWN  = 6'b001000,
    PH_RED_UP     = 6'b010000,
    PH_GREEN_DOWN = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] blue;
  } lamp_t;

  typedef struct packed {
    logic                  last_button;
    logic [LevelW-1:0]     tick_count;
    logic                  level_mode;
    logic [ColorSlotW-1:0] color_slot;
    logic [IntSlotW-1:0]   intensity_slot;
    logic [LevelW-1:0]     intensity_level;
    lamp_t                 lamp;
    phase_t                phase;
  } state_t;

  typedef struct packed {
    lamp_t lamp;
    logic  level_mode;
  } result_t;

  // Intensity level for each intensity slot
  function automatic logic [LevelW-1:0] level_of(input logic [IntSlotW-1:0] slot);
    logic [LevelW-1:0] lvl;
    unique case (slot)
      4'd0:    lvl = 8'd31;
      4'd1:    lvl = 8'd63;
      4'd2:    lvl = 8'd95;
      4'd3:    lvl = 8'd127;
      4'd4:    lvl = 8'd159;
      4'd5:    lvl = 8'd191;
      4'd6:    lvl = 8'd223;
      4'd7:    lvl = 8'd255;
      default: lvl = 8'd0;
    endcase
    return lvl;
  endfunction

  // Green, red, blue on/off mask; the rainbow slot wraps onto red
  function automatic logic [2:0] hue_of(input logic [ColorSlotW-1:0] slot);
    logic [2:0] mask;
    unique case (slot)
      3'd1:    mask = 3'b100;
      3'd2:    mask = 3'b001;
      3'd3:    mask = 3'b110;
      3'd4:    mask = 3'b011;
      3'd5:    mask = 3'b101;
      3'd6:    mask = 3'b111;
      default: mask = 3'b010;
    endcase
    return mask;
  endfunction

  function automatic lamp_t fixed_color(input logic [ColorSlotW-1:0] slot,
                                        input logic [LevelW-1:0] lvl);
    logic [2:0] mask;
    lamp_t      c;
    mask    = hue_of(slot);
    c.green = mask[2] ? lvl : '0;
    c.red   = mask[1] ? lvl : '0;
    c.blue  = mask[0] ? lvl : '0;
    return c;
  endfunction

endpackage

// ----- rtl/blcc_if.sv -----
// Handshake channel interfaces for button requests and lamp color results.
// Depends on blcc_pkg for field widths.
interface blcc_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

interface blcc_out_if;
  logic                        valid;
  logic                        ready;
  logic [blcc_pkg::LevelW-1:0] green_level;
  logic [blcc_pkg::LevelW-1:0] red_level;
  logic [blcc_pkg::LevelW-1:0] blue_level;
  logic                        intensity_mode_led;

  modport source (output valid, output green_level, output red_level, output blue_level,
                  output intensity_mode_led, input ready);
  modport sink   (input valid, input green_level, input red_level, input blue_level,
                  input intensity_mode_led, output ready);
endinterface

// ----- rtl/button_lamp_color_controller.sv -----
// Top level of the button lamp color controller: input register, state and
// configuration registers, next-state logic and result register.
// Depends on blcc_pkg, blcc_if, blcc_next and blcc_out_reg.
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+-------------------------------------------
//   in_chan   | in  | valid/ready   | button_level
//   out_chan  | out | valid/ready   | green_level, red_level, blue_level,
//             |     |               | intensity_mode_led
//   cfg_*     | in  | write enable  | cfg_index (2 bits), cfg_wdata (8 bits)
//
// One request per clock while out_chan is ready; a result is presented after its
// request passes the input register, then the result register.
// The tick's state update is one pass of logic from the input register into
// the state and result registers.
// Reset (synchronous, rst_n low) restores the power-up lamp state and defaults.
// A stalled result holds; the input register keeps its request until the
// result register frees, so in_chan.ready is high when empty or can_load.
module button_lamp_color_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  blcc_in_if.sink                            in_chan,
  blcc_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  logic [blcc_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [blcc_pkg::LevelW-1:0]        cfg_wdata
);
  import blcc_pkg::*;

  logic              in_valid_r;
  logic              in_valid_nxt;
  logic              in_button_r;
  logic              advance;
  logic              can_load;
  logic              in_take;
  logic [LevelW-1:0] long_press_r;
  logic [LevelW-1:0] idle_timeout_r;
  state_t            state_r;
  state_t            state_nxt;
  result_t           result;

  assign advance       = in_valid_r && can_load;
  assign in_chan.ready = !in_valid_r || can_load;
  assign in_take       = in_chan.valid && in_chan.ready;

  // Input register
  always_comb begin
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_button_r <= in_chan.button_level;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r   <= LevelW'(10);
      idle_timeout_r <= LevelW'(20);
    end else if (cfg_we) begin
      if (cfg_index == CFG_LONG_PRESS) begin
        long_press_r <= cfg_wdata;
      end else if (cfg_index == CFG_IDLE_TIMEOUT) begin
        idle_timeout_r <= cfg_wdata;
      end
    end
  end

  blcc_next u_next (
    .cur                (state_r),
    .button_level       (in_button_r),
    .long_press_ticks   (long_press_r),
    .idle_timeout_ticks (idle_timeout_r),
    .nxt                (state_nxt)
  );

  // Lamp state, advanced once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.last_button     <= 1'b1;
      state_r.tick_count      <= '0;
      state_r.level_mode      <= 1'b0;
      state_r.color_slot      <= '0;
      state_r.intensity_slot  <= IntSlotW'(2);
      state_r.intensity_level <= LevelW'(95);
      state_r.lamp.green      <= '0;
      state_r.lamp.red        <= LevelW'(95);
      state_r.lamp.blue       <= '0;
      state_r.phase           <= PH_BLUE_UP;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  assign result.lamp       = state_nxt.lamp;
  assign result.level_mode = state_nxt.level_mode;

  blcc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .load_data (result),
    .can_load  (can_load),
    .out_chan  (out_chan)
  );

endmodule

// ----- rtl/blcc_next.sv -----
// Next-state logic for one tick: edge detection, click handling, idle timeout
// and one rainbow fade step. Depends on blcc_pkg.
module blcc_next (
  input  blcc_pkg::state_t                cur,
  input  logic                            button_level,
  input  logic [blcc_pkg::LevelW-1:0]     long_press_ticks,
  input  logic [blcc_pkg::LevelW-1:0]     idle_timeout_ticks,
  output blcc_pkg::state_t                nxt
);
  import blcc_pkg::*;

  state_t              s;
  logic                press;
  logic                release_edge;
  logic [IntSlotW-1:0] islot_inc;

  assign press        = !button_level && cur.last_button;
  assign release_edge = button_level && !cur.last_button;
  assign islot_inc    = cur.intensity_slot + IntSlotW'(1);

  always_comb begin
    s = cur;

    // Handle edges and the idle timeout
    if (press) begin
      s.tick_count = '0;
    end else if (release_edge) begin
      if (cur.tick_count < long_press_ticks) begin
        if (cur.level_mode) begin
          // Step intensity, wrapping after the last level
          s.intensity_slot  = (cur.intensity_slot >= LAST_LEVEL) ? '0 : islot_inc;
          s.intensity_level = level_of(s.intensity_slot);
          if (cur.color_slot != RAINBOW_SLOT) begin
            s.lamp = fixed_color(cur.color_slot, s.intensity_level);
          end
        end else begin
          // Step color, rainbow after the seven fixed colors
          s.color_slot = cur.color_slot + ColorSlotW'(1);
          if (s.color_slot == RAINBOW_SLOT) begin
            s.lamp.green = '0;
            s.lamp.red   = cur.intensity_level;
            s.lamp.blue  = '0;
            s.phase      = PH_BLUE_UP;
          end else begin
            s.lamp = fixed_color(s.color_slot, cur.intensity_level);
          end
        end
      end else begin
        s.level_mode = 1'b1;
      end
      s.tick_count = '0;
    end else if (button_level && cur.last_button) begin
      if (cur.level_mode && (cur.tick_count > idle_timeout_ticks)) begin
        s.level_mode = 1'b0;
      end
    end
    s.last_button = button_level;

    // Advance the rainbow fade
    if (s.color_slot == RAINBOW_SLOT) begin
      unique case (s.phase)
        PH_BLUE_UP: begin
          s.lamp.blue = s.lamp.blue + LevelW'(1);
          if (s.lamp.blue >= s.intensity_level) s.phase = PH_RED_DOWN;
        end
        PH_RED_DOWN: begin
          s.lamp.red = s.lamp.red - LevelW'(1);
          if (s.lamp.red == '0) s.phase = PH_GREEN_UP;
        end
        PH_GREEN_UP: begin
          s.lamp.green = s.lamp.green + LevelW'(1);
          if (s.lamp.green >= s.intensity_level) s.phase = PH_BLUE_DOWN;
        end
        PH_BLUE_DOWN: begin
          s.lamp.blue = s.lamp.blue - LevelW'(1);
          if (s.lamp.blue == '0) s.phase = PH_RED_UP;
        end
        PH_RED_UP: begin
          s.lamp.red = s.lamp.red + LevelW'(1);
          if (s.lamp.red >= s.intensity_level) s.phase = PH_GREEN_DOWN;
        end
        PH_GREEN_DOWN: begin
          s.lamp.green = s.lamp.green - LevelW'(1);
          if (s.lamp.green == '0) s.phase = PH_BLUE_UP;
        end
        default: begin
        end
      endcase
    end

    s.tick_count = s.tick_count + LevelW'(1);
    nxt = s;
  end

endmodule

// ----- rtl/blcc_out_reg.sv -----
// Result register with valid flag that holds a color result until it is taken.
// Depends on blcc_pkg and blcc_out_if.
module blcc_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  blcc_pkg::result_t load_data,
  output logic              can_load,
  blcc_out_if.source        out_chan
);
  import blcc_pkg::*;

  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_data_r;

  // Free when empty or when the held result leaves this cycle
  assign can_load = !out_valid_r || out_chan.ready;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= load_data;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.green_level        = out_data_r.lamp.green;
  assign out_chan.red_level          = out_data_r.lamp.red;
  assign out_chan.blue_level         = out_data_r.lamp.blue;
  assign out_chan.intensity_mode_led = out_data_r.level_mode;

endmodule
